// ===== src/ihht_pkg.sv =====
`default_nettype none
package ihht_pkg;
  localparam int BUCKET_BITS_DEF = 10;
  localparam int SLOTS_DEF = 16;
  localparam int CACHE_DEF = 5;
  localparam int HANDLE_DEF = 48;
  localparam logic [31:0] INVALID_ID = 32'h7F000000;
  localparam logic [31:0] EXT_CHAR_MIN = 32'hFF000001;
  localparam logic [31:0] EXT_OBJ_MAX = 32'hFEFFFFFF;
  localparam logic [31:0] TOP_BIT = 32'h80000000;
  localparam logic [31:0] CNT0_RST = 32'h00000000;
  localparam logic [31:0] CNT1_RST = 32'h7FFFFFFF;
  localparam logic [31:0] CNT2_RST = 32'h80000000;
  localparam logic [31:0] CNT3_RST = 32'hFFFFFFFF;

  localparam logic [2:0] REQ_LOOKUP = 3'd0;
  localparam logic [2:0] REQ_ADD = 3'd1;
  localparam logic [2:0] REQ_ADD_EXT = 3'd2;
  localparam logic [2:0] REQ_ADD_INT = 3'd3;
  localparam logic [2:0] REQ_DEL = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BADID = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_READ, S_SCAN, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic load;     // capture request, update counters
    logic read;     // issue bucket row read
    logic scan;     // register match results
    logic commit;   // table / cache / fill writes
    logic done;     // present result
  } cmd_t;

  typedef struct packed {
    logic early;    // request finishes without a table access
    logic clearing; // fill clearing pass after reset still running
  } stat_t;
endpackage
`default_nettype wire

// ===== src/ihht_ctrl.sv =====
`default_nettype none
module ihht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ihht_pkg::stat_t stat,
  output ihht_pkg::cmd_t     cmd,
  output logic               busy
);
  ihht_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ihht_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ihht_pkg::S_IDLE: if (start && !stat.clearing) state_next = ihht_pkg::S_PREP;
      ihht_pkg::S_PREP: state_next = stat.early ? ihht_pkg::S_DONE : ihht_pkg::S_READ;
      ihht_pkg::S_READ: state_next = ihht_pkg::S_SCAN;
      ihht_pkg::S_SCAN: state_next = ihht_pkg::S_WRITE;
      ihht_pkg::S_WRITE: state_next = ihht_pkg::S_DONE;
      ihht_pkg::S_DONE: state_next = ihht_pkg::S_IDLE;
      default: state_next = ihht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ihht_pkg::S_IDLE: begin
        busy = stat.clearing;
        cmd.load = start && !stat.clearing;
      end
      ihht_pkg::S_PREP: cmd.read = !stat.early;
      ihht_pkg::S_READ: cmd.scan = 1'b1;
      ihht_pkg::S_SCAN: cmd.commit = 1'b1;
      ihht_pkg::S_WRITE: ;
      ihht_pkg::S_DONE: cmd.done = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/ihht_dp.sv =====
`default_nettype none
module ihht_dp #(
  parameter int BUCKET_BITS = ihht_pkg::BUCKET_BITS_DEF,
  parameter int SLOTS_PER_BUCKET = ihht_pkg::SLOTS_DEF,
  parameter int CACHE_ENTRIES = ihht_pkg::CACHE_DEF,
  parameter int HANDLE_BITS = ihht_pkg::HANDLE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ihht_pkg::cmd_t         cmd,
  output ihht_pkg::stat_t             stat,
  input  wire logic [3:0]             bucket_bits_cfg,
  input  wire logic [2:0]             req_type,
  input  wire logic [31:0]            object_id,
  input  wire logic [HANDLE_BITS-1:0] object_handle,
  input  wire logic                   is_character,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [31:0]                 result_id,
  output logic [HANDLE_BITS-1:0]      result_handle,
  output logic [31:0]                 next_object_internal,
  output logic [31:0]                 next_char_internal,
  output logic [31:0]                 next_object_external,
  output logic [31:0]                 next_char_external
);
  localparam int NB = 1 << BUCKET_BITS;
  localparam int SW = $clog2(SLOTS_PER_BUCKET);
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int BW = (BUCKET_BITS > 4) ? BUCKET_BITS : 4;

  // one row holds a whole bucket
  logic [31:0]            mem_ids [NB][SLOTS_PER_BUCKET];
  logic [HANDLE_BITS-1:0] mem_hdl [NB][SLOTS_PER_BUCKET];
  logic [FW-1:0]          fill [NB];

  logic [31:0]            cache_ids [CACHE_ENTRIES];
  logic [HANDLE_BITS-1:0] cache_hdl [CACHE_ENTRIES];
  logic [31:0]            cnt_oi, cnt_ci, cnt_oe, cnt_ce;

  logic [2:0]             req;
  logic [31:0]            id;
  logic [HANDLE_BITS-1:0] hdl;
  logic                   early;
  logic [1:0]             st;
  logic [HANDLE_BITS-1:0] rh;
  logic [BUCKET_BITS-1:0] bkt;

  logic [31:0]            row_ids [SLOTS_PER_BUCKET];
  logic [HANDLE_BITS-1:0] row_hdl [SLOTS_PER_BUCKET];
  logic [FW-1:0]          row_n;

  logic                   thit;
  logic [SW-1:0]          tidx;

  // fill clearing pass, one bucket per cycle after reset
  logic                   clr;
  logic [BUCKET_BITS-1:0] clr_idx;

  // input-stage decode
  logic [31:0] id_in, ext_id;
  logic        early_in;
  logic [1:0]  st_in;
  logic [31:0] oi_next, ci_next, oe_next, ce_next;
  logic        chit_in;
  logic [CW-1:0] cidx_in;
  logic [BW-1:0] nbits;
  logic [BUCKET_BITS-1:0] bmask;

  always_comb begin
    nbits = BW'(bucket_bits_cfg);
    if (nbits > BW'(BUCKET_BITS)) nbits = BW'(BUCKET_BITS);
    bmask = BUCKET_BITS'((({{BUCKET_BITS{1'b0}}, 1'b1} << nbits) - 1'b1));
  end

  always_comb begin
    ext_id = object_id | ihht_pkg::TOP_BIT;
    id_in = object_id;
    oi_next = cnt_oi; ci_next = cnt_ci; oe_next = cnt_oe; ce_next = cnt_ce;
    early_in = 1'b0;
    st_in = ihht_pkg::ST_BADID;
    chit_in = 1'b0;
    cidx_in = '0;
    for (int k = CACHE_ENTRIES - 1; k >= 0; k--)
      if (cache_ids[k] == object_id) begin
        chit_in = 1'b1;
        cidx_in = CW'(k);
      end
    case (req_type)
      ihht_pkg::REQ_LOOKUP: begin
        if (object_id == ihht_pkg::INVALID_ID) early_in = 1'b1;
        else if (chit_in) begin
          early_in = 1'b1;
          st_in = ihht_pkg::ST_OK;
        end
      end
      ihht_pkg::REQ_ADD: ;
      ihht_pkg::REQ_ADD_EXT: begin
        id_in = ext_id;
        if (ext_id[30:24] == 7'h7F) begin
          if (ext_id >= ihht_pkg::EXT_CHAR_MIN) begin
            if (ext_id - 32'd1 < cnt_ce) ce_next = ext_id - 32'd1;
          end else early_in = 1'b1;
        end else if (ext_id <= ihht_pkg::EXT_OBJ_MAX) begin
          if (ext_id + 32'd1 > cnt_oe) oe_next = ext_id + 32'd1;
        end else early_in = 1'b1;
      end
      ihht_pkg::REQ_ADD_INT: begin
        if (is_character) begin
          id_in = cnt_ci;
          ci_next = cnt_ci - 32'd1;
        end else begin
          id_in = cnt_oi;
          oi_next = cnt_oi + 32'd1;
        end
      end
      ihht_pkg::REQ_DEL: if (object_id == ihht_pkg::INVALID_ID) early_in = 1'b1;
      default: early_in = 1'b1;
    endcase
    if (!early_in && req_type != ihht_pkg::REQ_LOOKUP && req_type != ihht_pkg::REQ_DEL) begin
      if (object_handle == '0) begin
        early_in = 1'b1;
        st_in = ihht_pkg::ST_NULL;
      end else if (id_in == ihht_pkg::INVALID_ID) early_in = 1'b1;
    end
  end

  always_comb begin
    stat.early = early;
    stat.clearing = clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= 1'b1;
      clr_idx <= '0;
    end else if (clr) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == BUCKET_BITS'(NB - 1)) clr <= 1'b0;
    end
  end

  // request capture, then result status and handle at commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
      id <= id_in;
      hdl <= object_handle;
      early <= early_in;
      st <= st_in;
      // only a cache hit on a lookup answers with a handle here
      rh <= (st_in == ihht_pkg::ST_OK) ? cache_hdl[cidx_in] : '0;
      bkt <= id_in[BUCKET_BITS-1:0] & bmask;
    end else if (cmd.commit) begin
      if (req == ihht_pkg::REQ_LOOKUP || req == ihht_pkg::REQ_DEL) begin
        st <= thit ? ihht_pkg::ST_OK : ihht_pkg::ST_BADID;
        rh <= thit ? row_hdl[tidx] : '0;
      end else begin
        rh <= '0;
        if (thit) st <= ihht_pkg::ST_BADID;
        else if (row_n >= FW'(SLOTS_PER_BUCKET)) st <= ihht_pkg::ST_FULL;
        else st <= ihht_pkg::ST_OK;
      end
    end
  end

  // bucket row read, registered
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      row_ids <= mem_ids[bkt];
      row_hdl <= mem_hdl[bkt];
      row_n <= (fill[bkt] > FW'(SLOTS_PER_BUCKET)) ? FW'(SLOTS_PER_BUCKET) : fill[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      thit <= 1'b0;
      tidx <= '0;
      for (int k = SLOTS_PER_BUCKET - 1; k >= 0; k--)
        if (FW'(k) < row_n && row_ids[k] == id) begin
          thit <= 1'b1;
          tidx <= SW'(k);
        end
    end
  end

  logic [SW-1:0] last;
  assign last = SW'(row_n - FW'(1));

  // table and fill writes
  always_ff @(posedge clk) begin
    if (clr) begin
      fill[clr_idx] <= '0;
    end else if (cmd.commit) begin
      if (req == ihht_pkg::REQ_DEL) begin
        if (thit) fill[bkt] <= row_n - FW'(1);
      end else if (req != ihht_pkg::REQ_LOOKUP) begin
        if (!thit && row_n < FW'(SLOTS_PER_BUCKET)) fill[bkt] <= row_n + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req == ihht_pkg::REQ_DEL) begin
        if (thit) begin
          mem_ids[bkt][tidx] <= row_ids[last];
          mem_hdl[bkt][tidx] <= row_hdl[last];
        end
      end else if (req != ihht_pkg::REQ_LOOKUP) begin
        if (!thit && row_n < FW'(SLOTS_PER_BUCKET)) begin
          mem_ids[bkt][SW'(row_n)] <= id;
          mem_hdl[bkt][SW'(row_n)] <= hdl;
        end
      end
    end
  end

  // cache and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        cache_ids[k] <= ihht_pkg::INVALID_ID;
        cache_hdl[k] <= '0;
      end
      cnt_oi <= ihht_pkg::CNT0_RST;
      cnt_ci <= ihht_pkg::CNT1_RST;
      cnt_oe <= ihht_pkg::CNT2_RST;
      cnt_ce <= ihht_pkg::CNT3_RST;
      done <= 1'b0;
    end else begin
      done <= cmd.done;
      if (cmd.load) begin
        cnt_oi <= oi_next; cnt_ci <= ci_next;
        cnt_oe <= oe_next; cnt_ce <= ce_next;
        // cache hit moves to the front
        if (req_type == ihht_pkg::REQ_LOOKUP && chit_in &&
            object_id != ihht_pkg::INVALID_ID) begin
          for (int k = 1; k < CACHE_ENTRIES; k++)
            if (CW'(k) <= cidx_in) begin
              cache_ids[k] <= cache_ids[k-1];
              cache_hdl[k] <= cache_hdl[k-1];
            end
          cache_ids[0] <= object_id;
          cache_hdl[0] <= cache_hdl[cidx_in];
        end
        if (req_type == ihht_pkg::REQ_DEL && object_id != ihht_pkg::INVALID_ID)
          for (int k = 0; k < CACHE_ENTRIES; k++)
            if (cache_ids[k] == object_id) cache_ids[k] <= ihht_pkg::INVALID_ID;
      end
      if (cmd.commit && req == ihht_pkg::REQ_LOOKUP && thit) begin
        for (int k = 1; k < CACHE_ENTRIES; k++) begin
          cache_ids[k] <= cache_ids[k-1];
          cache_hdl[k] <= cache_hdl[k-1];
        end
        cache_ids[0] <= id;
        cache_hdl[0] <= row_hdl[tidx];
      end
    end
  end

  assign status = st;
  assign result_id = id;
  assign result_handle = rh;
  assign next_object_internal = cnt_oi;
  assign next_char_internal = cnt_ci;
  assign next_object_external = cnt_oe;
  assign next_char_external = cnt_ce;
endmodule
`default_nettype wire

// ===== src/id_handle_hash_table_with_mru_cache_unit.sv =====
// Id-to-handle map with a compact hashed bucket table and an MRU lookup cache.
// Early requests (lookup cache hits, invalid ids, failed add checks, unknown codes) go
// from PREP to DONE; others read the bucket row via READ, SCAN and WRITE first.
// New requests wait until the last one is done; the receiver cannot stall results.
// Reset (synchronous): cache invalid, id counters to defaults, bucket width 10, then
// a pass clears all 2^BUCKET_BITS bucket fills (1024 by default) with busy high.
`default_nettype none
module id_handle_hash_table_with_mru_cache_unit #(
  parameter int BUCKET_BITS = ihht_pkg::BUCKET_BITS_DEF,
  parameter int SLOTS_PER_BUCKET = ihht_pkg::SLOTS_DEF,
  parameter int CACHE_ENTRIES = ihht_pkg::CACHE_DEF,
  parameter int HANDLE_BITS = ihht_pkg::HANDLE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [2:0]             req_type,
  input  wire logic [31:0]            object_id,
  input  wire logic [HANDLE_BITS-1:0] object_handle,
  input  wire logic                   is_character,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [3:0]             cfg_data,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [31:0]                 result_id,
  output logic [HANDLE_BITS-1:0]      result_handle,
  output logic [31:0]                 next_object_internal,
  output logic [31:0]                 next_char_internal,
  output logic [31:0]                 next_object_external,
  output logic [31:0]                 next_char_external
);
  ihht_pkg::cmd_t  cmd;
  ihht_pkg::stat_t stat;
  logic [3:0] bucket_bits_cfg;

  // config register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_bits_cfg <= 4'd10;
    else if (cfg_valid) bucket_bits_cfg <= cfg_data;
  end

  ihht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  ihht_dp #(
    .BUCKET_BITS(BUCKET_BITS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
    .CACHE_ENTRIES(CACHE_ENTRIES), .HANDLE_BITS(HANDLE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .bucket_bits_cfg(bucket_bits_cfg),
    .req_type(req_type), .object_id(object_id), .object_handle(object_handle),
    .is_character(is_character), .done(done), .status(status),
    .result_id(result_id), .result_handle(result_handle),
    .next_object_internal(next_object_internal),
    .next_char_internal(next_char_internal),
    .next_object_external(next_object_external),
    .next_char_external(next_char_external)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // request codes the block treats as unknown
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam int NBKT = 1 << ihht_pkg::BUCKET_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1230;

  // one request as driven, plus an optional typed-in status
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] id;
    logic [47:0] hdl;
    logic        chr;
    logic        typed;
    logic [1:0]  st;
  } request_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] rid;
    logic [47:0] rhdl;
    logic [31:0] obj_int;
    logic [31:0] chr_int;
    logic [31:0] obj_ext;
    logic [31:0] chr_ext;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] req_type = '0;
  logic [31:0] object_id = '0;
  logic [47:0] object_handle = '0;
  logic is_character = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [31:0] result_id;
  logic [47:0] result_handle;
  logic [31:0] next_object_internal, next_char_internal;
  logic [31:0] next_object_external, next_char_external;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  id_handle_hash_table_with_mru_cache_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .object_id(object_id), .object_handle(object_handle),
    .is_character(is_character),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .result_id(result_id),
    .result_handle(result_handle),
    .next_object_internal(next_object_internal),
    .next_char_internal(next_char_internal),
    .next_object_external(next_object_external),
    .next_char_external(next_char_external)
  );

  // ---------------- shadow map state ----------------
  logic [31:0] tbl_id [NBKT*ihht_pkg::SLOTS_DEF];
  logic [47:0] tbl_hdl [NBKT*ihht_pkg::SLOTS_DEF];
  int unsigned fill [NBKT];
  logic [31:0] mru_id [ihht_pkg::CACHE_DEF];
  logic [47:0] mru_hdl [ihht_pkg::CACHE_DEF];
  logic [31:0] ctr [4];
  logic [3:0] bkt_bits;

  answer_t pending[$];
  int errors = 0;
  int unsigned cycles = 0;
  logic [31:0] id_pool[$];

  function automatic int unsigned bucket_sel(logic [31:0] id);
    int unsigned nb;
    nb = (bkt_bits > ihht_pkg::BUCKET_BITS_DEF) ? ihht_pkg::BUCKET_BITS_DEF : bkt_bits;
    return id & ((32'd1 << nb) - 1);
  endfunction

  // shift cache entries [0..upto-1] down one and put (id, h) at the front
  function automatic void mru_push(int upto, logic [31:0] id, logic [47:0] h);
    for (int k = upto; k > 0; k--) begin
      mru_id[k] = mru_id[k-1];
      mru_hdl[k] = mru_hdl[k-1];
    end
    mru_id[0] = id;
    mru_hdl[0] = h;
  endfunction

  function automatic logic [1:0] table_insert(logic [31:0] id, logic [47:0] h);
    int unsigned b, base, n;
    if (h == '0) return ihht_pkg::ST_NULL;
    if (id == ihht_pkg::INVALID_ID) return ihht_pkg::ST_BADID;
    b = bucket_sel(id);
    base = b * ihht_pkg::SLOTS_DEF;
    n = fill[b];
    for (int k = 0; k < n; k++)
      if (tbl_id[base+k] == id) return ihht_pkg::ST_BADID;
    if (n >= ihht_pkg::SLOTS_DEF) return ihht_pkg::ST_FULL;
    tbl_id[base+n] = id;
    tbl_hdl[base+n] = h;
    fill[b] = n + 1;
    return ihht_pkg::ST_OK;
  endfunction

  // advance the shadow state by one request and return its answer
  function automatic answer_t map_step(request_t r);
    answer_t a;
    logic [31:0] id;
    logic [1:0] st;
    logic [47:0] rh;
    logic hit;
    int unsigned b, base, n;
    id = r.id;
    st = ihht_pkg::ST_BADID;
    rh = '0;
    hit = 1'b0;
    case (r.op)
      ihht_pkg::REQ_LOOKUP: begin
        if (id != ihht_pkg::INVALID_ID) begin
          for (int k = 0; k < ihht_pkg::CACHE_DEF && !hit; k++)
            if (mru_id[k] == id) begin
              rh = mru_hdl[k];
              mru_push(k, id, rh);
              st = ihht_pkg::ST_OK;
              hit = 1'b1;
            end
          if (!hit) begin
            b = bucket_sel(id);
            base = b * ihht_pkg::SLOTS_DEF;
            n = fill[b];
            for (int k = 0; k < n && !hit; k++)
              if (tbl_id[base+k] == id) begin
                rh = tbl_hdl[base+k];
                mru_push(ihht_pkg::CACHE_DEF - 1, id, rh);
                st = ihht_pkg::ST_OK;
                hit = 1'b1;
              end
          end
        end
      end
      ihht_pkg::REQ_ADD: st = table_insert(id, r.hdl);
      ihht_pkg::REQ_ADD_EXT: begin
        id = id | ihht_pkg::TOP_BIT;
        if ((id & ihht_pkg::INVALID_ID) == ihht_pkg::INVALID_ID) begin
          // char range: bound is the lowest char id
          if (id >= ihht_pkg::EXT_CHAR_MIN) begin
            if (id - 1 < ctr[3]) ctr[3] = id - 1;
            st = table_insert(id, r.hdl);
          end
        end else if (id <= ihht_pkg::EXT_OBJ_MAX) begin
          if (id + 1 > ctr[2]) ctr[2] = id + 1;
          st = table_insert(id, r.hdl);
        end
      end
      ihht_pkg::REQ_ADD_INT: begin
        // counters move whether or not the insert succeeds
        if (r.chr) begin
          id = ctr[1];
          ctr[1] = id - 1;
        end else begin
          id = ctr[0];
          ctr[0] = id + 1;
        end
        st = table_insert(id, r.hdl);
      end
      ihht_pkg::REQ_DEL: begin
        if (id != ihht_pkg::INVALID_ID) begin
          for (int k = 0; k < ihht_pkg::CACHE_DEF; k++)
            if (mru_id[k] == id) mru_id[k] = ihht_pkg::INVALID_ID;
          b = bucket_sel(id);
          base = b * ihht_pkg::SLOTS_DEF;
          n = fill[b];
          for (int k = 0; k < n && !hit; k++)
            if (tbl_id[base+k] == id) begin
              // last entry fills the hole
              rh = tbl_hdl[base+k];
              tbl_id[base+k] = tbl_id[base+n-1];
              tbl_hdl[base+k] = tbl_hdl[base+n-1];
              fill[b] = n - 1;
              st = ihht_pkg::ST_OK;
              hit = 1'b1;
            end
        end
      end
      default: ;
    endcase
    if (st != ihht_pkg::ST_OK ||
        (r.op != ihht_pkg::REQ_LOOKUP && r.op != ihht_pkg::REQ_DEL)) rh = '0;
    a.st = st;
    a.rid = id;
    a.rhdl = rh;
    a.obj_int = ctr[0];
    a.chr_int = ctr[1];
    a.obj_ext = ctr[2];
    a.chr_ext = ctr[3];
    return a;
  endfunction

  initial begin
    for (int k = 0; k < NBKT; k++) fill[k] = 0;
    for (int k = 0; k < ihht_pkg::CACHE_DEF; k++) begin
      mru_id[k] = ihht_pkg::INVALID_ID;
      mru_hdl[k] = '0;
    end
    ctr[0] = ihht_pkg::CNT0_RST;
    ctr[1] = ihht_pkg::CNT1_RST;
    ctr[2] = ihht_pkg::CNT2_RST;
    ctr[3] = ihht_pkg::CNT3_RST;
    bkt_bits = 4'd10;
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending.pop_front();
        if (status !== e.st) begin
          $error("status exp %0h got %0h", e.st, status); errors++;
        end
        if (result_id !== e.rid) begin
          $error("result_id exp %0h got %0h", e.rid, result_id); errors++;
        end
        if (result_handle !== e.rhdl) begin
          $error("result_handle exp %0h got %0h", e.rhdl, result_handle); errors++;
        end
        if (next_object_internal !== e.obj_int) begin
          $error("next_object_internal exp %0h got %0h", e.obj_int,
                 next_object_internal); errors++;
        end
        if (next_char_internal !== e.chr_int) begin
          $error("next_char_internal exp %0h got %0h", e.chr_int,
                 next_char_internal); errors++;
        end
        if (next_object_external !== e.obj_ext) begin
          $error("next_object_external exp %0h got %0h", e.obj_ext,
                 next_object_external); errors++;
        end
        if (next_char_external !== e.chr_ext) begin
          $error("next_char_external exp %0h got %0h", e.chr_ext,
                 next_char_external); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL id_handle_hash_table_with_mru_cache_unit");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  // start stays high across back-to-back requests; a gap, a drain or a width change lowers it
  task automatic issue(request_t r);
    answer_t a;
    start <= 1'b1;
    req_type <= r.op;
    object_id <= r.id;
    object_handle <= r.hdl;
    is_character <= r.chr;
    do @(posedge clk); while (busy);
    a = map_step(r);
    if (r.typed) a.st = r.st;
    pending.push_back(a);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain, let the pipe go quiet, then write the bucket width
  task automatic set_width(logic [3:0] v);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bkt_bits = v;
  endtask

  function automatic logic [47:0] rand_hdl();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int unsigned w;
    r = '0;
    r.hdl = rand_hdl();
    r.chr = 1'($urandom_range(0, 1));
    w = $urandom_range(0, 99);
    if (w < 30) r.op = ihht_pkg::REQ_LOOKUP;
    else if (w < 52) r.op = ihht_pkg::REQ_ADD;
    else if (w < 60) r.op = ihht_pkg::REQ_ADD_EXT;
    else if (w < 68) r.op = ihht_pkg::REQ_ADD_INT;
    else if (w < 95) r.op = ihht_pkg::REQ_DEL;
    else begin
      case ($urandom_range(0, 2))
        0: r.op = REQ_RSVD5;
        1: r.op = REQ_RSVD6;
        default: r.op = REQ_RSVD7;
      endcase
    end
    // mostly reuse known ids so lookups and deletes hit
    w = $urandom_range(0, 99);
    if (id_pool.size() != 0 && w < 65)
      r.id = id_pool[$urandom_range(0, id_pool.size() - 1)];
    else if (w < 75) r.id = {1'($urandom_range(0, 1)), 7'h7F, 24'($urandom())};
    else if (w < 78) r.id = ihht_pkg::INVALID_ID;
    else if (w < 88) r.id = $urandom_range(0, 63);
    else r.id = $urandom();
    if (r.op == ihht_pkg::REQ_ADD || r.op == ihht_pkg::REQ_ADD_EXT) begin
      id_pool.push_back(r.op == ihht_pkg::REQ_ADD_EXT ? (r.id | ihht_pkg::TOP_BIT) : r.id);
      if (id_pool.size() > 48) void'(id_pool.pop_front());
    end
    return r;
  endfunction

  // ---------------- stimulus ----------------
  request_t rows[];
  logic [3:0] widths[6] = '{4'd0, 4'd2, 4'd15, 4'd4, 4'd1, 4'd10};

  initial begin
    rows = '{
      // invalid id and empty table
      '{ihht_pkg::REQ_LOOKUP, ihht_pkg::INVALID_ID, 48'h1, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{ihht_pkg::REQ_LOOKUP, 32'h0, 48'h0, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{ihht_pkg::REQ_DEL, ihht_pkg::INVALID_ID, 48'h0, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      // add checks: null handle first, then invalid id
      '{ihht_pkg::REQ_ADD, ihht_pkg::INVALID_ID, 48'h0, 1'b0, 1'b1, ihht_pkg::ST_NULL},
      '{ihht_pkg::REQ_ADD, ihht_pkg::INVALID_ID, 48'h5, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{ihht_pkg::REQ_ADD, 32'h5, '1, 1'b0, 1'b1, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_ADD, 32'h5, 48'h9, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{ihht_pkg::REQ_ADD, '1, 48'h1, 1'b0, 1'b1, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_LOOKUP, 32'h5, 48'h0, 1'b0, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_LOOKUP, 32'h5, 48'h0, 1'b0, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_LOOKUP, '1, 48'h0, 1'b0, 1'b0, ihht_pkg::ST_OK},
      // external adds: char window edges and object max
      '{ihht_pkg::REQ_ADD_EXT, ihht_pkg::INVALID_ID, 48'h7, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{ihht_pkg::REQ_ADD_EXT, 32'h7F000001, 48'h7, 1'b0, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_ADD_EXT, 32'h7EFFFFFF, 48'h8, 1'b0, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_ADD_EXT, 32'h00000001, 48'h0, 1'b0, 1'b0, ihht_pkg::ST_NULL},
      '{ihht_pkg::REQ_ADD_EXT, 32'hFFFFFFFF, 48'h3, 1'b0, 1'b0, ihht_pkg::ST_OK},
      // internal adds, both counters; the second object add has a null handle
      '{ihht_pkg::REQ_ADD_INT, 32'h0, 48'hABC, 1'b0, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_ADD_INT, 32'h0, 48'hDEF, 1'b1, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_ADD_INT, 32'h0, 48'h0, 1'b0, 1'b0, ihht_pkg::ST_NULL},
      // delete, then delete again
      '{ihht_pkg::REQ_DEL, 32'h5, 48'h0, 1'b0, 1'b0, ihht_pkg::ST_OK},
      '{ihht_pkg::REQ_DEL, 32'h5, 48'h0, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{ihht_pkg::REQ_LOOKUP, 32'h5, 48'h0, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{REQ_RSVD5, 32'h5, 48'h1, 1'b0, 1'b1, ihht_pkg::ST_BADID},
      '{REQ_RSVD6, 32'h0, 48'h1, 1'b1, 1'b1, ihht_pkg::ST_BADID},
      '{REQ_RSVD7, '1, '1, 1'b1, 1'b1, ihht_pkg::ST_BADID}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) issue(rows[i]);

    // random part: six width settings, last phase without gaps
    for (int ph = 0; ph < 6; ph++) begin
      set_width(widths[ph]);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        issue(rand_request());
        if (ph < 5 && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 16));
        // sender waits for every result once, in the third phase
        if (ph == 2 && i == 50) begin
          start <= 1'b0;
          while (pending.size() != 0) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0)
      $display("PASS id_handle_hash_table_with_mru_cache_unit");
    else
      $display("FAIL id_handle_hash_table_with_mru_cache_unit");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/ihht_pkg.sv
src/ihht_ctrl.sv
src/ihht_dp.sv
src/id_handle_hash_table_with_mru_cache_unit.sv
tb/sv/tb_top.sv
